/* rtl/assert_macros.svh */
// Assertion macros shared by the byte unstuffing decoder RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset.
`define BUD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
// Condition must never be true at a rising edge outside reset.
`define BUD_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define BUD_ASSERT(lbl, clk, rst, prop, msg)
`define BUD_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

/* rtl/bud_pkg.sv */
// Shared types and constants of the byte unstuffing decoder.
// No dependencies; used by bud_decode, bud_fifo and byte_unstuffing_decoder.
`default_nettype none

package bud_pkg;

   // result buffer depth (at least four: one in-flight byte can push two results)
   localparam int unsigned FifoDepth    = 8;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   typedef struct packed {
      logic [7:0] a_first;
      logic [7:0] a_second;
      logic [7:0] a_result;
      logic [7:0] b_first;
      logic [7:0] b_second;
      logic [7:0] b_result;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } result_type;

   typedef enum logic [2:0] {
      REG_A_FIRST  = 3'd0,
      REG_A_SECOND = 3'd1,
      REG_A_RESULT = 3'd2,
      REG_B_FIRST  = 3'd3,
      REG_B_SECOND = 3'd4,
      REG_B_RESULT = 3'd5
   } reg_index_type;

   localparam cfg_type CfgReset = '{
      a_first:  8'd219,
      a_second: 8'd220,
      a_result: 8'd192,
      b_first:  8'd219,
      b_second: 8'd221,
      b_result: 8'd219
   };

endpackage

`default_nettype wire

/* rtl/byte_unstuffing_decoder.sv */
// Top level of the byte unstuffing decoder: APB register file, input stage,
// decode step and result buffer. Depends on bud_pkg, bud_decode, bud_fifo.
`default_nettype none
`include "assert_macros.svh"

// Byte unstuffing decoder. Each req transaction carries one stuffed byte and
// a last-of-packet flag; each rsp transaction carries one decoded byte. When
// the held byte and the incoming byte form escape pair A (checked first) or
// pair B, the two are replaced by that pair's result byte. A byte equal to
// either pair's first byte is held back until the next byte decides; at the
// end of a packet a held byte is flushed, and the last byte of a packet is
// never held. Rate: one req transaction per cycle while each byte yields at
// most one decoded byte and rsp is not stalled; the rsp side delivers one
// byte per cycle, so a byte that flushes a held byte and also passes itself
// puts two decoded bytes on it. An accepted byte is captured in the input
// register, decoded from there into the result buffer, and offered on rsp
// from the buffer head. req_stall rises when the result buffer (FIFO_DEPTH
// entries) cannot take two more results from both the input register and a
// new transaction. Registers sit at byte address 4*i, with paddr[1:0] not
// decoded: 0 pair A first, 1 pair A second, 2 pair A result, 3 pair B
// first, 4 pair B second, 5 pair B result; slots 6 and 7 read zero and
// ignore writes. Write them only while no transaction is in flight.
module byte_unstuffing_decoder #(
   parameter int unsigned FIFO_DEPTH = bud_pkg::FifoDepth
) (
   input  logic                               clock,
   input  logic                               reset,
   // stuffed byte stream
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_in_byte,
   input  logic                               req_in_last,
   // decoded byte stream
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_out_last,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bud_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [bud_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [bud_pkg::CsrDataWidth-1:0]   prdata,
   output logic                               pready
);

   localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
   // headroom test is done one bit wider so the sum cannot wrap
   localparam logic [CntW:0] RoomLimit = (CntW + 1)'(FIFO_DEPTH - 2);
   localparam logic [CntW:0] DepthW    = (CntW + 1)'(FIFO_DEPTH);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   bud_pkg::cfg_type       cfg_ff, cfg_in;
   bud_pkg::reg_index_type csr_index;
   logic                   csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = bud_pkg::reg_index_type'(paddr[bud_pkg::CsrAddrWidth-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (csr_index)
         bud_pkg::REG_A_FIRST: begin
            prdata[7:0] = cfg_ff.a_first;
            if (csr_write) cfg_in.a_first = pwdata[7:0];
         end
         bud_pkg::REG_A_SECOND: begin
            prdata[7:0] = cfg_ff.a_second;
            if (csr_write) cfg_in.a_second = pwdata[7:0];
         end
         bud_pkg::REG_A_RESULT: begin
            prdata[7:0] = cfg_ff.a_result;
            if (csr_write) cfg_in.a_result = pwdata[7:0];
         end
         bud_pkg::REG_B_FIRST: begin
            prdata[7:0] = cfg_ff.b_first;
            if (csr_write) cfg_in.b_first = pwdata[7:0];
         end
         bud_pkg::REG_B_SECOND: begin
            prdata[7:0] = cfg_ff.b_second;
            if (csr_write) cfg_in.b_second = pwdata[7:0];
         end
         bud_pkg::REG_B_RESULT: begin
            prdata[7:0] = cfg_ff.b_result;
            if (csr_write) cfg_in.b_result = pwdata[7:0];
         end
         default: begin
            // unmapped slot: reads zero, writes dropped
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bud_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic            stage_valid_ff, stage_valid_in;
   logic [7:0]      stage_byte_ff, stage_byte_in;
   logic            stage_last_ff, stage_last_in;
   logic [CntW-1:0] fifo_count;
   logic [CntW:0]   committed;
   logic            req_take;

   // results already in the buffer plus the worst case still in the stage
   assign committed = {1'b0, fifo_count} + (stage_valid_ff ? (CntW + 1)'(2) : '0);
   assign req_stall = (committed > RoomLimit);
   assign req_take  = req_valid && !req_stall;

   assign stage_valid_in = req_take;
   assign stage_byte_in  = req_take ? req_in_byte : stage_byte_ff;
   assign stage_last_in  = req_take ? req_in_last : stage_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_byte_ff <= stage_byte_in;
      stage_last_ff <= stage_last_in;
   end

   // ---------------------------------------------------------------------
   // Decode against the held byte
   // ---------------------------------------------------------------------
   logic                held_valid_ff, held_valid_in;
   logic [7:0]          held_byte_ff, held_byte_in;
   bud_pkg::result_type res0;
   bud_pkg::result_type res1;
   logic [1:0]          res_count;
   logic                dec_held_valid;
   logic [7:0]          dec_held_byte;
   logic [1:0]          push_count;

   bud_decode u_decode (
      .cfg             (cfg_ff),
      .held_valid      (held_valid_ff),
      .held_byte       (held_byte_ff),
      .in_byte         (stage_byte_ff),
      .in_last         (stage_last_ff),
      .res0            (res0),
      .res1            (res1),
      .res_count       (res_count),
      .held_valid_next (dec_held_valid),
      .held_byte_next  (dec_held_byte)
   );

   assign push_count    = stage_valid_ff ? res_count : 2'd0;
   assign held_valid_in = stage_valid_ff ? dec_held_valid : held_valid_ff;
   assign held_byte_in  = stage_valid_ff ? dec_held_byte  : held_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

   // ---------------------------------------------------------------------
   // Result buffer and rsp channel
   // ---------------------------------------------------------------------
   bud_pkg::result_type head;
   logic                fifo_not_empty;

   bud_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .pop        (rsp_valid && !rsp_stall),
      .head       (head),
      .not_empty  (fifo_not_empty),
      .count      (fifo_count)
   );

   assign rsp_valid    = fifo_not_empty;
   assign rsp_out_byte = head.data;
   assign rsp_out_last = head.last;

   // stage contents must always fit, even if they expand to two results
   `BUD_ASSERT(a_stage_fits, clock, reset, stage_valid_ff |-> ({1'b0, fifo_count} + (CntW + 1)'(2) <= DepthW), "input stage lacks buffer room")
   // a packet's last byte leaves nothing held
   `BUD_ASSERT(a_last_clears_held, clock, reset, (stage_valid_ff && stage_last_ff) |=> !held_valid_ff, "byte held across packet end")

endmodule

`default_nettype wire

/* rtl/bud_decode.sv */
// Single-pass unstuffing decision for one stuffed byte against the held byte.
// Depends on bud_pkg (cfg_type, result_type).
`default_nettype none

module bud_decode (
   input  bud_pkg::cfg_type    cfg,
   input  logic                held_valid,
   input  logic [7:0]          held_byte,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output bud_pkg::result_type res0,
   output bud_pkg::result_type res1,
   output logic [1:0]          res_count,
   output logic                held_valid_next,
   output logic [7:0]          held_byte_next
);

   logic                hit_a;
   logic                hit_b;
   logic                cur_emit;
   bud_pkg::result_type cur_res;
   bud_pkg::result_type held_res;

   // pair A wins over pair B
   assign hit_a = held_valid && (held_byte == cfg.a_first) && (in_byte == cfg.a_second);
   assign hit_b = held_valid && (held_byte == cfg.b_first) && (in_byte == cfg.b_second);

   // last byte never opens a pair
   assign cur_emit = in_last || !((in_byte == cfg.a_first) || (in_byte == cfg.b_first));

   assign cur_res.data  = in_byte;
   assign cur_res.last  = in_last;
   assign held_res.data = held_byte;
   assign held_res.last = 1'b0;

   always_comb begin
      res0            = cur_res;
      res1            = cur_res;
      res_count       = {1'b0, cur_emit};
      held_valid_next = !cur_emit;
      held_byte_next  = in_byte;
      if (hit_a) begin
         res0.data       = cfg.a_result;
         res_count       = 2'd1;
         held_valid_next = 1'b0;
      end else if (hit_b) begin
         res0.data       = cfg.b_result;
         res_count       = 2'd1;
         held_valid_next = 1'b0;
      end else if (held_valid) begin
         // flush held byte first, current byte behind it
         res0      = held_res;
         res_count = cur_emit ? 2'd2 : 2'd1;
      end
   end

endmodule

`default_nettype wire

/* rtl/bud_fifo.sv */
// Result buffer: takes up to two results a cycle, hands out one a cycle.
// Depends on bud_pkg (result_type) and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bud_fifo #(
   parameter int unsigned DEPTH = bud_pkg::FifoDepth
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [1:0]                         push_count,
   input  bud_pkg::result_type                push0,
   input  bud_pkg::result_type                push1,
   input  logic                               pop,
   output bud_pkg::result_type                head,
   output logic                               not_empty,
   output logic [$clog2(DEPTH+1)-1:0]         count
);

   localparam int unsigned PtrW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntMax  = CntW'(DEPTH);
   localparam logic [CntW-1:0] CntRoom2 = CntW'(DEPTH - 2);

   bud_pkg::result_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] wr_next1;
   logic [PtrW-1:0] wr_next2;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      ptr_inc = (p == PtrLast) ? '0 : p + PtrW'(1);
   endfunction

   assign wr_next1 = ptr_inc(wr_ptr_ff);
   assign wr_next2 = ptr_inc(wr_next1);

   always_comb begin
      case (push_count)
         2'd1:    wr_ptr_in = wr_next1;
         2'd2:    wr_ptr_in = wr_next2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push_count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next1] <= push1;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

   `BUD_NEVER(a_fifo_overfull, clock, reset, count_ff > CntMax, "result buffer over depth")
   `BUD_NEVER(a_fifo_push_room, clock, reset, (push_count != 2'd0) && (count_ff > CntRoom2), "push without room for two")

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for byte_unstuffing_decoder: stuffed bytes in, decoded bytes out.
// Depends on rtl/bud_pkg.sv and the decoder RTL; nothing else is read or needed.
`default_nettype none

module tb;

   // Run limits and drain time (input register plus decode stage, with margin)
   localparam int CycleLimit = 500000;
   localparam int DrainCycles = 8;
   localparam int PhaseItems = 220;
   localparam int PhaseCount = 8;
   localparam int AddrW = bud_pkg::CsrAddrWidth;
   localparam int DataW = bud_pkg::CsrDataWidth;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stuffed_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // stuffed byte channel
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_in_last = 1'b0;

   // decoded byte channel
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   // register port
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [AddrW-1:0] paddr = '0;
   logic [DataW-1:0] pwdata = '0;
   logic [DataW-1:0] prdata;
   logic             pready;

   // predictor state: own copy of the registers and of the held byte
   bud_pkg::cfg_type model_cfg = bud_pkg::CfgReset;
   logic [7:0]       model_held_byte = 8'd0;
   logic             model_held_valid = 1'b0;

   stuffed_type         stuffed_q[$];   // bytes waiting to be offered on req
   bud_pkg::result_type decoded_q[$];   // decoded bytes still owed by the block

   int idle_pct = 0;            // chance per cycle that the sender stays idle
   int stall_pct = 0;           // chance per cycle that the receiver stalls
   int mismatch_count = 0;
   int cycle_count = 0;

   byte_unstuffing_decoder u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Decoder prediction for one accepted byte. Pair A wins over pair B; a
   // held byte that does not complete a pair is released ahead of the new one.
   task automatic unstuff_byte(input logic [7:0] x, input logic last);
      logic [7:0] h;
      if (model_held_valid) begin
         h = model_held_byte;
         model_held_valid = 1'b0;
         model_held_byte = 8'd0;
         if (h == model_cfg.a_first && x == model_cfg.a_second) begin
            decoded_q.push_back('{data: model_cfg.a_result, last: last});
            return;
         end
         if (h == model_cfg.b_first && x == model_cfg.b_second) begin
            decoded_q.push_back('{data: model_cfg.b_result, last: last});
            return;
         end
         decoded_q.push_back('{data: h, last: 1'b0});
      end
      // last byte of a packet is never held: the byte past the end cannot match
      if (last)
         decoded_q.push_back('{data: x, last: 1'b1});
      else if (x == model_cfg.a_first || x == model_cfg.b_first) begin
         model_held_byte = x;
         model_held_valid = 1'b1;
      end else
         decoded_q.push_back('{data: x, last: 1'b0});
   endtask

   // Driver: predicts each accepted transaction, then offers the next queued
   // byte unless it decides to idle. A stalled transaction is held unchanged.
   always @(posedge clock) begin
      stuffed_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            unstuff_byte(req_in_byte, req_in_last);
         if (!req_valid || !req_stall) begin
            if (stuffed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = stuffed_q.pop_front();
               req_valid   <= 1'b1;
               req_in_byte <= nxt.data;
               req_in_last <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted decoded byte with the oldest prediction
   always @(posedge clock) begin
      bud_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            $error("out_byte: expected nothing, got %0h (out_last %0b)",
                   rsp_out_byte, rsp_out_last);
            mismatch_count++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h, got %0h", want.data, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %0b, got %0b", want.last, rsp_out_last);
               mismatch_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // APB write: setup cycle, then access; the register takes the value at the
   // edge where psel, penable, pwrite and pready are all high.
   task automatic csr_write(input int idx, input logic [7:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AddrW'(idx * 4);
      pwdata  <= {24'($urandom()), val};   // upper bits are not part of any register
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         bud_pkg::REG_A_FIRST:  model_cfg.a_first  = val;
         bud_pkg::REG_A_SECOND: model_cfg.a_second = val;
         bud_pkg::REG_A_RESULT: model_cfg.a_result = val;
         bud_pkg::REG_B_FIRST:  model_cfg.b_first  = val;
         bud_pkg::REG_B_SECOND: model_cfg.b_second = val;
         bud_pkg::REG_B_RESULT: model_cfg.b_result = val;
         default: ;   // unmapped address, write dropped
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_pairs(input logic [7:0] a1, a2, ar, b1, b2, br);
      csr_write(bud_pkg::REG_A_FIRST, a1);
      csr_write(bud_pkg::REG_A_SECOND, a2);
      csr_write(bud_pkg::REG_A_RESULT, ar);
      csr_write(bud_pkg::REG_B_FIRST, b1);
      csr_write(bud_pkg::REG_B_SECOND, b2);
      csr_write(bud_pkg::REG_B_RESULT, br);
   endtask

   // Sender holds off until every owed byte has come out, then lets the
   // decode pipeline settle (a held byte owes nothing yet).
   task automatic wait_drained();
      @(negedge clock);
      while (stuffed_q.size() != 0 || req_valid || decoded_q.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic last);
      stuffed_q.push_back('{data: data, last: last});
   endtask

   initial begin
      int n;
      int len;
      int sel;
      int mode;
      logic [7:0] b;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed transactions with the reset pairs (A = DB DC -> C0, B = DB DD -> DB)
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hDB, 1'b0); queue_byte(8'hDC, 1'b0);            // pair A
      queue_byte(8'hDB, 1'b0); queue_byte(8'hDD, 1'b0);            // pair B
      queue_byte(8'hDB, 1'b0); queue_byte(8'h41, 1'b0);            // held, no pair
      queue_byte(8'hDB, 1'b0); queue_byte(8'hDB, 1'b0);            // held replaced by held
      queue_byte(8'hDC, 1'b0);
      queue_byte(8'hDB, 1'b1);                                     // last never held
      queue_byte(8'hDB, 1'b0); queue_byte(8'hDC, 1'b1);            // pair closing a packet
      queue_byte(8'hDB, 1'b0); queue_byte(8'h41, 1'b1);            // flush at packet end
      queue_byte(8'hDB, 1'b0); queue_byte(8'hDB, 1'b1);            // held, then last escape
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b1);

      for (int p = 0; p < PhaseCount; p++) begin
         wait_drained();
         case (p)
            0: ;   // stay on reset pairs
            1: begin
               load_pairs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
               csr_write(6, 8'hA5);   // beyond the register map
               csr_write(7, 8'h5A);
            end
            2: load_pairs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            3: load_pairs(8'h7E, 8'h5E, 8'h11, 8'h7E, 8'h5E, 8'h22);   // A shadows B
            4: load_pairs(8'h7E, 8'h5E, 8'h7E, 8'h7D, 8'h5D, 8'h7D);   // distinct escapes
            default: load_pairs(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)));
         endcase
         @(negedge clock);
         // idling modes in turn: none, sender idle, receiver stalling, both
         mode = p % 4;
         idle_pct  = (mode == 1) ? 74 : (mode == 3) ? 31 : 0;
         stall_pct = (mode == 2) ? 74 : (mode == 3) ? 31 : 0;

         n = 0;
         while (n < PhaseItems) begin
            if ($urandom_range(9) == 0) begin
               // noise: any byte, any flag
               queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
               n++;
            end else begin
               // packet rich in escape bytes, occasionally long
               len = ($urandom_range(15) == 0) ? $urandom_range(40, 20)
                                               : $urandom_range(10, 1);
               for (int i = 0; i < len; i++) begin
                  sel = $urandom_range(9);
                  case (sel)
                     0, 1: b = model_cfg.a_first;
                     2, 3: b = model_cfg.b_first;
                     4:    b = model_cfg.a_second;
                     5:    b = model_cfg.b_second;
                     default: b = 8'($urandom_range(255));
                  endcase
                  queue_byte(b, i == len - 1);
               end
               n += len;
            end
         end
         // leave an escape byte held across the next register update
         queue_byte(model_cfg.a_first, 1'b0);
      end

      // flush whatever is held, then settle
      queue_byte(8'($urandom_range(255)), 1'b1);
      wait_drained();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
